// File: src/gftq_pkg.sv
// ----------------------------------------------------------------------------
// gftq_pkg
// Shared constants, codes and types of the grouped team queue.
// ----------------------------------------------------------------------------
package gftq_pkg;

   // sizes (team count and queue depth are powers of two: pointers wrap
   // naturally)
   localparam int ELEM_BITS        = 10;
   localparam int ELEM_COUNT       = 1 << ELEM_BITS;
   localparam int NUM_TEAMS        = 16;
   localparam int TEAM_BITS        = $clog2(NUM_TEAMS);
   localparam int TEAM_QUEUE_DEPTH = 64;
   localparam int QPTR_BITS        = $clog2(TEAM_QUEUE_DEPTH);
   localparam int QCNT_BITS        = QPTR_BITS + 1;
   localparam int OCNT_BITS        = TEAM_BITS + 1;
   localparam int SLOT_ADDR_BITS   = TEAM_BITS + QPTR_BITS;

   localparam logic [QCNT_BITS-1:0] QCNT_FULL = QCNT_BITS'(TEAM_QUEUE_DEPTH);
   localparam logic [OCNT_BITS-1:0] OCNT_FULL = OCNT_BITS'(NUM_TEAMS);

   // opcodes
   localparam logic [1:0] OP_ASSIGN  = 2'd0;
   localparam logic [1:0] OP_ENQUEUE = 2'd1;
   localparam logic [1:0] OP_DEQUEUE = 2'd2;
   localparam logic [1:0] OP_CLEAR   = 2'd3;

   // result status
   localparam logic [1:0] STAT_DONE      = 2'd0;
   localparam logic [1:0] STAT_DEQUEUED  = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_FULL_DROP = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic                 sweep;      // clear one team map entry
      logic [ELEM_BITS-1:0] sweep_addr;
      logic                 accept;     // latch word, launch memory reads
      logic                 commit;     // update state, load result register
   } ctl_cmd_type;

endpackage

// File: src/gftq_ctrl.sv
// ----------------------------------------------------------------------------
// gftq_ctrl
// Sequencer: map clearing sweep after reset, accept / execute per word,
// result valid flag.
// ----------------------------------------------------------------------------
module gftq_ctrl
   import gftq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [ELEM_BITS-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      cmd          = '0;
      cmd.sweep_addr = sweep_cnt_ff;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep    = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // result register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/gftq_dp.sv
// ----------------------------------------------------------------------------
// gftq_dp
// Datapath: team map and slot memories, per-team ring pointers, team order
// ring, result register.
// ----------------------------------------------------------------------------
module gftq_dp
   import gftq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   input  logic [1:0]           req_opcode,
   input  logic [ELEM_BITS-1:0] req_element,
   input  logic [TEAM_BITS-1:0] req_team,
   output logic [1:0]           rsp_status,
   output logic [ELEM_BITS-1:0] rsp_element,
   output logic [TEAM_BITS-1:0] rsp_team
);

   // memories
   logic [TEAM_BITS-1:0] team_map_mem [ELEM_COUNT];
   logic [ELEM_BITS-1:0] slot_mem [NUM_TEAMS * TEAM_QUEUE_DEPTH];
   logic [TEAM_BITS-1:0] map_rd_ff;
   logic [ELEM_BITS-1:0] slot_rd_ff;

   // queue state
   logic [QPTR_BITS-1:0] heads_ff  [NUM_TEAMS];
   logic [QCNT_BITS-1:0] counts_ff [NUM_TEAMS];
   logic [TEAM_BITS-1:0] order_ff  [NUM_TEAMS];
   logic [TEAM_BITS-1:0] order_head_ff;
   logic [OCNT_BITS-1:0] order_count_ff;

   // latched word
   logic [1:0]           op_ff;
   logic [ELEM_BITS-1:0] elem_ff;
   logic [TEAM_BITS-1:0] team_ff;
   logic [TEAM_BITS-1:0] deq_team_ff;

   logic [1:0]           status_ff;
   logic [ELEM_BITS-1:0] out_elem_ff;
   logic [TEAM_BITS-1:0] out_team_ff;

   logic [TEAM_BITS-1:0]      front_team;
   logic [SLOT_ADDR_BITS-1:0] deq_addr;
   logic [QCNT_BITS-1:0]      enq_cnt;
   logic                      enq_full;
   logic [QPTR_BITS-1:0]      enq_pos;
   logic [TEAM_BITS-1:0]      order_tail;
   logic                      deq_ok;
   logic [QCNT_BITS-1:0]      deq_cnt;
   logic                      do_enq;
   logic                      do_deq;

   // front team and its head slot, valid while one word is in flight
   assign front_team = order_ff[order_head_ff];
   assign deq_addr   = {front_team, heads_ff[front_team]};

   assign enq_cnt    = counts_ff[map_rd_ff];
   assign enq_full   = (enq_cnt == QCNT_FULL);
   assign enq_pos    = heads_ff[map_rd_ff] + enq_cnt[QPTR_BITS-1:0];
   assign order_tail = order_head_ff + order_count_ff[TEAM_BITS-1:0];

   assign deq_cnt = counts_ff[deq_team_ff];
   assign deq_ok  = (order_count_ff != '0) && (deq_cnt != '0);

   assign do_enq = cmd.commit && (op_ff == OP_ENQUEUE) && !enq_full;
   assign do_deq = cmd.commit && (op_ff == OP_DEQUEUE) && deq_ok;

   // team map: sweep port, assign write, read at accept
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         team_map_mem[cmd.sweep_addr] <= '0;
      end else if (cmd.commit && (op_ff == OP_ASSIGN)) begin
         // team field cannot exceed the team count, so every assign lands
         team_map_mem[elem_ff] <= team_ff;
      end
      if (cmd.accept) begin
         map_rd_ff <= team_map_mem[req_element];
      end
   end

   // team slots
   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_mem[{map_rd_ff, enq_pos}] <= elem_ff;
      end
      if (cmd.accept) begin
         slot_rd_ff <= slot_mem[deq_addr];
      end
   end

   // input latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= req_opcode;
         elem_ff     <= req_element;
         team_ff     <= req_team;
         deq_team_ff <= front_team;
      end
   end

   // order ring entries: no reset, read only behind the count
   always_ff @(posedge clock) begin
      if (do_enq && (enq_cnt == '0) && (order_count_ff < OCNT_FULL)) begin
         order_ff[order_tail] <= map_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.commit && (op_ff == OP_CLEAR))) begin
         for (int i = 0; i < NUM_TEAMS; i++) begin
            heads_ff[i]  <= '0;
            counts_ff[i] <= '0;
         end
         order_head_ff  <= '0;
         order_count_ff <= '0;
      end else if (do_enq) begin
         counts_ff[map_rd_ff] <= enq_cnt + 1'b1;
         if ((enq_cnt == '0) && (order_count_ff < OCNT_FULL)) begin
            order_count_ff <= order_count_ff + 1'b1;
         end
      end else if (do_deq) begin
         heads_ff[deq_team_ff]  <= heads_ff[deq_team_ff] + 1'b1;
         counts_ff[deq_team_ff] <= deq_cnt - 1'b1;
         if (deq_cnt == QCNT_BITS'(1)) begin
            order_head_ff  <= order_head_ff + 1'b1;
            order_count_ff <= order_count_ff - 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_elem_ff <= '0;
         out_team_ff <= '0;
         unique case (op_ff)
            OP_ENQUEUE: begin
               status_ff <= enq_full ? STAT_FULL_DROP : STAT_DONE;
            end
            OP_DEQUEUE: begin
               if (deq_ok) begin
                  status_ff   <= STAT_DEQUEUED;
                  out_elem_ff <= slot_rd_ff;
                  out_team_ff <= deq_team_ff;
               end else begin
                  status_ff <= STAT_EMPTY;
               end
            end
            default: begin
               status_ff <= STAT_DONE;
            end
         endcase
      end
   end

   assign rsp_status  = status_ff;
   assign rsp_element = out_elem_ff;
   assign rsp_team    = out_team_ff;

endmodule

// File: src/grouped_fifo_team_queue.sv
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue
// Team queue: elements queue behind members of their own team, teams in the
// order they joined.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word: assign team, enqueue, dequeue or clear.
//   rsp_* returns exactly one result word per command (status, and for a
//   successful dequeue the element and its team; zeros otherwise).
//   Timing: a word is latched in the accept cycle and executed in the
//   execute state, which commits its result once the result register is free;
//   no new word is taken before that commit. A dequeue reads the slot memory
//   at the front team's head in the accept cycle and uses it in the execute cycle.
//   Reset: synchronous, active high. Afterwards the 1024-entry team map is
//   swept to team 0, one entry a cycle, so req_tready stays low until the
//   sweep is done. Queues come up empty.
//   Stall: the result sits in an output register; a new word is taken while
//   it waits, but the next result only commits once rsp_tready frees the
//   register, and until then req_tready stays low.
//   Enqueue into a full team queue drops the element (status 3); dequeue on
//   an empty line gives status 2.
// ----------------------------------------------------------------------------
module grouped_fifo_team_queue
   import gftq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[1:0], element[11:2], team[15:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[1:0], out_element[11:2], out_team[15:12]
);

   ctl_cmd_type          cmd;
   logic [1:0]           rsp_status;
   logic [ELEM_BITS-1:0] rsp_element;
   logic [TEAM_BITS-1:0] rsp_team;

   // sequencer
   gftq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // memories and queue state
   gftq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_opcode  (req_tdata[1:0]),
      .req_element (req_tdata[ELEM_BITS+1:2]),
      .req_team    (req_tdata[15:ELEM_BITS+2]),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_team    (rsp_team)
   );

   assign rsp_tdata = {rsp_team, rsp_element, rsp_status};

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------

   // one word in flight: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accepted back to back");

   // a commit always presents a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed result not presented");

   // sweep and item traffic never overlap
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> (!cmd.accept && !cmd.commit && !req_tready))
      else $error("word handled during map sweep");

   // only a dequeued result carries element and team
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != STAT_DEQUEUED)) |-> (rsp_tdata[15:2] == '0))
      else $error("payload on non-dequeue result");

endmodule

// File: tb/team_queue_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_queue_check
// Watches both streams of the team queue. It keeps its own copy of the team
// map, the per-team rings and the team order, predicts one result word per
// accepted command word, and compares each returned word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module team_queue_check
   import gftq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // opcode[1:0], element[11:2], team[15:12]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // status[1:0], out_element[11:2], out_team[15:12]
   output int          mismatches,
   output int          pending
);

   typedef struct packed {
      logic [TEAM_BITS-1:0] team;
      logic [ELEM_BITS-1:0] element;
      logic [1:0]           opcode;
   } command_word_type;

   typedef struct packed {
      logic [TEAM_BITS-1:0] out_team;
      logic [ELEM_BITS-1:0] out_element;
      logic [1:0]           status;
   } result_word_type;

   // shadow state
   logic [TEAM_BITS-1:0] member_team [ELEM_COUNT];
   logic [ELEM_BITS-1:0] team_ring   [NUM_TEAMS][TEAM_QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] ring_head   [NUM_TEAMS];
   logic [QCNT_BITS-1:0] ring_fill   [NUM_TEAMS];
   logic [TEAM_BITS-1:0] line_order  [NUM_TEAMS];
   logic [TEAM_BITS-1:0] line_front;
   logic [OCNT_BITS-1:0] line_len;

   result_word_type awaited_results [$];

   initial mismatches = 0;

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      $display("%0t ns: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   function automatic void empty_line();
      for (int t = 0; t < NUM_TEAMS; t++) begin
         ring_head[t] = '0;
         ring_fill[t] = '0;
      end
      line_front = '0;
      line_len   = '0;
   endfunction

   // Apply one command to the shadow state and return the word it should give.
   function automatic result_word_type team_queue_apply(input command_word_type cmd);
      result_word_type      res;
      logic [TEAM_BITS-1:0] t;
      logic [QPTR_BITS-1:0] pos;
      res = '0;
      res.status = STAT_DONE;
      unique case (cmd.opcode)
         OP_ASSIGN: begin
            if (int'(cmd.team) < NUM_TEAMS)
               member_team[cmd.element] = cmd.team;
         end
         OP_ENQUEUE: begin
            t = member_team[cmd.element];
            if (ring_fill[t] == QCNT_FULL) begin
               res.status = STAT_FULL_DROP;
            end else begin
               pos = ring_head[t] + QPTR_BITS'(ring_fill[t]);
               // a team joins the back of the line when it has nobody waiting
               if (ring_fill[t] == '0 && line_len < OCNT_FULL) begin
                  line_order[TEAM_BITS'(line_front + TEAM_BITS'(line_len))] = t;
                  line_len++;
               end
               team_ring[t][pos] = cmd.element;
               ring_fill[t]++;
            end
         end
         OP_DEQUEUE: begin
            if (line_len == '0) begin
               res.status = STAT_EMPTY;
            end else begin
               t = line_order[line_front];
               if (ring_fill[t] == '0) begin
                  res.status = STAT_EMPTY;
               end else begin
                  res.status      = STAT_DEQUEUED;
                  res.out_element = team_ring[t][ring_head[t]];
                  res.out_team    = t;
                  ring_head[t]++;
                  ring_fill[t]--;
                  // team leaves the line once its own queue drains
                  if (ring_fill[t] == '0) begin
                     line_front++;
                     line_len--;
                  end
               end
            end
         end
         OP_CLEAR: empty_line();   // map survives a clear
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      result_word_type  got;
      result_word_type  want;
      command_word_type cmd;
      if (reset) begin
         for (int e = 0; e < ELEM_COUNT; e++)
            member_team[e] = '0;
         empty_line();
         awaited_results.delete();
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result word", 0, int'(got));
            end else begin
               want = awaited_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.out_element != want.out_element)
                  report_mismatch("out_element", want.out_element, got.out_element);
               if (got.out_team != want.out_team)
                  report_mismatch("out_team", want.out_team, got.out_team);
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = req_tdata;
            awaited_results.push_back(team_queue_apply(cmd));
         end
         pending <= awaited_results.size();
      end
   end

endmodule

// File: tb/grouped_fifo_team_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue_test
// Drives command words into the team queue and gives the verdict; a checker
// beside the block predicts and compares every result word. A short directed
// run covers ordering, reassignment, empty line and clear; random segments
// then mix commands and fill single teams to their depth and beyond.
// ----------------------------------------------------------------------------
module grouped_fifo_team_queue_test
   import gftq_pkg::*;
;

   localparam int WORD_TARGET = 1450;
   localparam int HOLD_AT     = 300;   // words sent before the long receiver hold
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // opcode[1:0], element[11:2], team[15:12]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // status[1:0], out_element[11:2], out_team[15:12]

   int   mismatches;
   int   pending;
   int   words_sent;
   logic idle_on;             // random idling on both sides

   grouped_fifo_team_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   team_queue_check check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit: far beyond the slowest correct run (map sweep, hold, stalls)
   initial begin
      #400000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: random stalls, plus one long hold that backs the block up
   // while the sender keeps offering words.
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            for (int c = 1; c < HOLD_CYCLES; c++)
               @(posedge clock);
         end else if (idle_on) begin
            rsp_tready <= ($urandom_range(0, 99) >= 26);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // One command word; valid stays up from word to word unless an idle
   // cycle is drawn.
   task automatic send_word(input logic [1:0] opcode,
                            input logic [ELEM_BITS-1:0] element,
                            input logic [TEAM_BITS-1:0] team);
      while (idle_on && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {team, element, opcode};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
      // long stretch with no idling at all
      idle_on = !(words_sent >= 600 && words_sent < 900);
   endtask

   // mostly a small pool so assignments and enqueues meet, with the extremes
   function automatic logic [ELEM_BITS-1:0] pick_element();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return $urandom_range(0, 1) ? ELEM_BITS'(ELEM_COUNT - 1) : '0;
      if (r <= 5)
         return ELEM_BITS'($urandom_range(0, 15));
      return ELEM_BITS'($urandom_range(0, ELEM_COUNT - 1));
   endfunction

   function automatic logic [TEAM_BITS-1:0] pick_team();
      if ($urandom_range(0, 1))
         return TEAM_BITS'($urandom_range(0, NUM_TEAMS - 1));
      return TEAM_BITS'($urandom_range(0, 3));
   endfunction

   initial begin
      logic [ELEM_BITS-1:0] e;
      logic [TEAM_BITS-1:0] t;
      int                   r;
      int                   n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      words_sent = 0;
      idle_on    = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      send_word(OP_DEQUEUE, '0, '0);            // empty line
      send_word(OP_ASSIGN,  10'd1023, 4'd15);
      send_word(OP_ASSIGN,  10'd5,    4'd15);
      send_word(OP_ASSIGN,  10'd6,    4'd7);
      send_word(OP_ENQUEUE, 10'd0,    4'd15);    // team 0 from the cleared map
      send_word(OP_ENQUEUE, 10'd1023, 4'd0);
      send_word(OP_ENQUEUE, 10'd6,    4'd0);
      send_word(OP_ENQUEUE, 10'd5,    4'd0);     // joins its team, ahead of team 7
      send_word(OP_ENQUEUE, 10'd1,    4'd0);
      send_word(OP_ASSIGN,  10'd1023, 4'd3);     // reassign while queued
      send_word(OP_ENQUEUE, 10'd1023, 4'd0);     // now lands in team 3
      repeat (6) send_word(OP_DEQUEUE, 10'd1023, 4'd15);
      send_word(OP_DEQUEUE, '0, '0);
      send_word(OP_ENQUEUE, 10'd6,    4'd0);
      send_word(OP_ENQUEUE, 10'd512,  4'd8);
      send_word(OP_CLEAR,   10'd1023, 4'd15);
      send_word(OP_DEQUEUE, '0, '0);             // empty after clear
      send_word(OP_ENQUEUE, 10'd6,    4'd0);     // map kept across clear
      send_word(OP_DEQUEUE, '0, '0);

      // --- random segments ---
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 99) < 15) begin
            // fill one team to near or past its depth, then drain to near or past empty
            e = pick_element();
            t = TEAM_BITS'($urandom_range(0, NUM_TEAMS - 1));
            send_word(OP_ASSIGN, e, t);
            n = $urandom_range(TEAM_QUEUE_DEPTH - 4, TEAM_QUEUE_DEPTH + 6);
            repeat (n) send_word(OP_ENQUEUE, e, TEAM_BITS'($urandom));
            n = $urandom_range(TEAM_QUEUE_DEPTH - 4, TEAM_QUEUE_DEPTH + 10);
            repeat (n) send_word(OP_DEQUEUE, ELEM_BITS'($urandom), TEAM_BITS'($urandom));
         end else begin
            repeat (40) begin
               r = $urandom_range(0, 99);
               if (r < 20)
                  send_word(OP_ASSIGN, pick_element(), pick_team());
               else if (r < 65)
                  send_word(OP_ENQUEUE, pick_element(), TEAM_BITS'($urandom));
               else if (r < 97)
                  send_word(OP_DEQUEUE, ELEM_BITS'($urandom), TEAM_BITS'($urandom));
               else
                  send_word(OP_CLEAR, ELEM_BITS'($urandom), TEAM_BITS'($urandom));
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain: the checker's pending count is registered behind acceptance
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
